// File: design/assert_macros.svh
// Assertion macros used by the checker.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tfla_pkg.sv
// Shared types and constants for the tagged free-list allocator.
// No dependencies; imported by the core, the RAM wrapper users and the checker.
package tfla_pkg;

    // Field widths fixed by the transaction format
    localparam int IDX_W      = 12;
    localparam int KIND_W     = 2;
    localparam int TAG_OUT_W  = 19;
    localparam int S_TDATA_W  = 16;
    localparam int M_FIELDS_W = 1 + IDX_W + TAG_OUT_W + 1;
    localparam int M_TDATA_W  = 40;

    // Defaults for the core parameters
    localparam int BLOCK_COUNT_DEF = 4096;
    localparam int TAG_BITS_DEF    = 19;

    localparam logic [TAG_OUT_W-1:0] WARN_LEVEL_RST = 19'd514287;

    // Operation codes carried in tuser
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;

    typedef enum logic [2:0] {
        ST_SWEEP = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

endpackage

// File: design/tfla_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tfla_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/tagged_free_list_allocator_core.sv
// Tagged free-list allocator: top level.
// Depends on tfla_pkg and tfla_ram (link store).
//
// Usage:
//   s_ channel: s_tuser carries the operation (allocate, free, check), s_tdata
//   the block index and the has-object flag. m_ channel: one result transaction
//   per accepted input with the grant, handed-out index, tag and warning flag.
//   cfg_we/cfg_wdata write warn_level; write only while the block is idle.
// Timing:
//   The accept cycle issues the link-store read for an allocate; ST_EXEC then
//   applies the result and loads the output register once that register is
//   free. No new input is taken meanwhile: s_tready is low in ST_EXEC and
//   returns high as the result is registered, unless a check starts a sweep.
// Reset and reinitialize:
//   After reset the link store is rebuilt, each block linking to the next and
//   the last to null, by a sweep over all BLOCK_COUNT entries (4096 at
//   default), during which s_tready is low. A check that finds the tag at its
//   maximum clears head and tag, returns its result, and runs the same sweep.
// Stall:
//   While m_tready is low the output register holds; one more input may be
//   accepted, and its result waits in the core until the register frees up.
module tagged_free_list_allocator_core import tfla_pkg::*; #(
    parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: block_index[11:0], has_object[12], zero pad [15:13]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: kind[1:0]
    input  logic [KIND_W-1:0]     s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // m_tdata: granted[0], allocated_index[12:1], tag_value[31:13],
    //          need_reset[32], zero pad [39:33]
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_we,
    input  logic [TAG_OUT_W-1:0]  cfg_wdata
);

    localparam int AW = $clog2(BLOCK_COUNT);
    localparam int LW = $clog2(BLOCK_COUNT + 1);
    localparam int XW = 33;
    localparam logic [LW-1:0] NULL_LINK = LW'(BLOCK_COUNT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(BLOCK_COUNT - 1);

    state_t                 state_reg, state_next;
    logic [AW-1:0]          sweep_cnt_reg, sweep_cnt_next;
    logic [LW-1:0]          head_reg, head_next;
    logic [TAG_BITS-1:0]    tag_reg, tag_next;
    logic [TAG_OUT_W-1:0]   warn_reg;
    logic [KIND_W-1:0]      kind_reg;
    logic [IDX_W-1:0]       blk_reg;
    logic                   has_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg;

    logic                   s_fire;
    logic                   commit;
    logic                   granted;
    logic [IDX_W-1:0]       alloc_idx;
    logic                   free_wr;
    logic                   rebuild;
    logic                   need_reset;
    logic [XW-1:0]          head_ext, blk_ext, tag_ext;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [LW-1:0]          ram_wdata, ram_rdata;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_EXEC) && (!m_valid_reg || m_tready);

    assign head_ext = XW'(head_reg);
    assign blk_ext  = XW'(blk_reg);

    // Link store: sweep writes the initial chain, a committed free pushes a block
    tfla_ram #(
        .WIDTH (LW),
        .DEPTH (BLOCK_COUNT)
    ) u_link_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Read the successor of the head as the allocate is accepted
    assign ram_re    = s_fire && (s_tuser == KIND_ALLOC);
    assign ram_raddr = head_reg[AW-1:0];

    always_comb begin
        if (state_reg == ST_SWEEP) begin
            ram_we    = 1'b1;
            ram_waddr = sweep_cnt_reg;
            ram_wdata = LW'(sweep_cnt_reg) + LW'(1);
        end else begin
            ram_we    = commit && free_wr;
            ram_waddr = blk_ext[AW-1:0];
            ram_wdata = head_reg;
        end
    end

    // Operation result; applied only on commit
    always_comb begin
        head_next = head_reg;
        tag_next  = tag_reg;
        granted   = 1'b0;
        alloc_idx = '0;
        free_wr   = 1'b0;
        rebuild   = 1'b0;
        case (kind_reg)
            KIND_ALLOC: begin
                if (head_reg < NULL_LINK) begin
                    granted   = 1'b1;
                    alloc_idx = head_ext[IDX_W-1:0];
                    head_next = ram_rdata;
                    tag_next  = tag_reg + TAG_BITS'(1);
                end
            end
            KIND_FREE: begin
                if (has_reg && (blk_ext < XW'(BLOCK_COUNT))) begin
                    free_wr   = 1'b1;
                    head_next = blk_ext[LW-1:0];
                    tag_next  = tag_reg + TAG_BITS'(1);
                end
            end
            KIND_CHECK: begin
                if (&tag_reg) begin
                    rebuild   = 1'b1;
                    head_next = '0;
                    tag_next  = '0;
                end
            end
            default: ;
        endcase
    end

    assign tag_ext    = XW'(tag_next);
    assign need_reset = (tag_ext >= XW'(warn_reg));

    always_comb begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        unique case (state_reg)
            ST_SWEEP: begin
                sweep_cnt_next = sweep_cnt_reg + AW'(1);
                if (sweep_cnt_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    if (rebuild) begin
                        state_next     = ST_SWEEP;
                        sweep_cnt_next = '0;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_SWEEP;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (commit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SWEEP;
            sweep_cnt_reg <= '0;
            head_reg      <= '0;
            tag_reg       <= '0;
            warn_reg      <= WARN_LEVEL_RST;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            m_valid_reg   <= m_valid_next;
            if (commit) begin
                head_reg <= head_next;
                tag_reg  <= tag_next;
            end
            if (cfg_we) begin
                warn_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers: hold the accepted transaction and the pending result
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg <= s_tuser;
            blk_reg  <= s_tdata[IDX_W-1:0];
            has_reg  <= s_tdata[IDX_W];
        end
        if (commit) begin
            m_tdata_reg <= {(M_TDATA_W - M_FIELDS_W)'(0), need_reset,
                            tag_ext[TAG_OUT_W-1:0], alloc_idx, granted};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: design/tfla_checker.sv
// Port-level checker for the tagged free-list allocator, bound to the core.
// Depends on tfla_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tfla_checker import tfla_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready
);

    // A result held under backpressure keeps its contents
    `ASSERT_CLK(a_m_hold, aclk, aresetn,
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)),
        "result changed while stalled")

    // One transaction in flight: input side closes right after an accept
    `ASSERT_CLK(a_one_in_flight, aclk, aresetn,
        (s_tvalid && s_tready) |=> !s_tready,
        "input accepted while a transaction is in flight")

    // A refused or non-allocate result reports index zero
    `ASSERT_CLK(a_idx_zero, aclk, aresetn,
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[IDX_W:1] == '0),
        "index reported without a grant")

    // Padding bits above the result fields stay clear
    `ASSERT_CLK(a_pad_zero, aclk, aresetn,
        m_tvalid |-> (m_tdata[M_TDATA_W-1:M_FIELDS_W] == '0),
        "nonzero padding in result")

endmodule

bind tagged_free_list_allocator_core tfla_checker u_tfla_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
